>>> hdl/ray_segment_intersection_unit_assert.svh
// Assertion macros for the ray/segment intersection unit.
// Included by every RTL file that carries concurrent checks; no dependencies.
`ifndef RAY_SEGMENT_INTERSECTION_UNIT_ASSERT_SVH
`define RAY_SEGMENT_INTERSECTION_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define RSI_ASSERT_NOW(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("rsi assertion failed");
// Check that cons holds in the cycle after ante.
`define RSI_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("rsi assertion failed");
`else
`define RSI_ASSERT_NOW(label, ck, rn, ante, cons)
`define RSI_ASSERT_NEXT(label, ck, rn, ante, cons)
`endif
`endif

>>> hdl/rsi_pkg.sv
// Shared widths, types and constants of the ray/segment intersection unit.
// No dependencies; compiled before every other file.
package rsi_pkg;

    // Field widths
    localparam int COORD_W = 24;
    localparam int DIR_W   = 16;

    // Derived arithmetic widths
    localparam int DIFF_W  = COORD_W + 1;       // endpoint/origin difference
    localparam int DPROD_W = DIFF_W + DIR_W;    // difference times direction
    localparam int DSUM_W  = DPROD_W + 1;       // determinant and segment numerator
    localparam int CPROD_W = 2 * DIFF_W;        // difference times difference
    localparam int CSUM_W  = CPROD_W + 1;       // ray numerator
    localparam int MAG_W   = DSUM_W;            // magnitude of determinant
    localparam int EW      = COORD_W;           // magnitude of an endpoint delta
    localparam int Q_W     = EW + 1;            // quotient of one axis
    localparam int SUM_W   = MAG_W + 2;         // partial remainder in a divide step
    localparam int PT_W    = COORD_W + 2;       // point before saturation
    localparam int STEPS   = EW;                // one quotient bit per stage

    // Lanes of the divider
    localparam int AXES   = 2;
    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIR_W-1:0]   dir_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [DPROD_W-1:0] dprod_t;
    typedef logic signed [DSUM_W-1:0]  dsum_t;
    typedef logic signed [CPROD_W-1:0] cprod_t;
    typedef logic signed [CSUM_W-1:0]  csum_t;
    typedef logic signed [PT_W-1:0]    pt_t;
    typedef logic [MAG_W-1:0]          mag_t;
    typedef logic [EW-1:0]             emag_t;
    typedef logic [Q_W-1:0]            quo_t;

    localparam pt_t PT_MAX = pt_t'((1 << (COORD_W - 1)) - 1);
    localparam pt_t PT_MIN = -PT_MAX - pt_t'(1);

    // Control bits that travel with each transaction
    typedef struct packed {
        logic valid;
        logic hit;
    } rsi_ctl_t;

    // Per-axis data of the wall: first endpoint, direction of the delta, |delta|
    typedef struct packed {
        coord_t p1;
        logic   neg;
        emag_t  mag;
    } rsi_axis_t;

    // Divider lane state: quotient so far and partial remainder
    typedef struct packed {
        quo_t q;
        mag_t r;
    } rsi_lane_t;

    // Result payload
    typedef struct packed {
        logic   hit;
        coord_t point_x;
        coord_t point_y;
    } rsi_res_t;

endpackage

>>> hdl/rsi_if.sv
// Valid/ready channel interfaces for ray requests and intersection results.
// Depends on rsi_pkg.
interface rsi_in_if
    import rsi_pkg::*;
();
    logic   valid;
    logic   ready;
    coord_t wall_start_x;
    coord_t wall_start_y;
    coord_t wall_end_x;
    coord_t wall_end_y;
    coord_t origin_x;
    coord_t origin_y;
    dir_t   dir_x;
    dir_t   dir_y;

    modport source (
        output valid, wall_start_x, wall_start_y, wall_end_x, wall_end_y,
               origin_x, origin_y, dir_x, dir_y,
        input  ready
    );
    modport sink (
        input  valid, wall_start_x, wall_start_y, wall_end_x, wall_end_y,
               origin_x, origin_y, dir_x, dir_y,
        output ready
    );
endinterface

interface rsi_out_if
    import rsi_pkg::*;
();
    logic   valid;
    logic   ready;
    logic   hit;
    coord_t point_x;
    coord_t point_y;

    modport source (
        output valid, hit, point_x, point_y,
        input  ready
    );
    modport sink (
        input  valid, hit, point_x, point_y,
        output ready
    );
endinterface

>>> hdl/ray_segment_intersection_unit.sv
// Ray versus wall-segment intersection, 2-D, exact fixed point: takes one
// transaction per clock while ready is high and returns one result per
// transaction, in order. The depth is set by the rounding divider that
// forms the point, one quotient bit per stage for each of the 24 bits of the
// wall delta; five stages of differences, products and tests precede it and
// a rounding stage and the output register follow. A two-entry output
// buffer lets the pipeline keep accepting while one finished result waits;
// ready drops only when both entries are full.
`include "ray_segment_intersection_unit_assert.svh"

module ray_segment_intersection_unit
    import rsi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    rsi_in_if.sink    ray,
    rsi_out_if.source result
);
    logic adv;

    // Stage 1: differences
    logic      s1_valid_reg;
    diff_t     s1_ex_reg, s1_ey_reg, s1_ax_reg, s1_ay_reg;
    dir_t      s1_rx_reg, s1_ry_reg;
    coord_t    s1_x1_reg, s1_y1_reg;

    // Stage 2: products
    logic      s2_valid_reg;
    dprod_t    s2_eyrx_reg, s2_exry_reg, s2_ayrx_reg, s2_axry_reg;
    cprod_t    s2_eyax_reg, s2_exay_reg;
    rsi_axis_t s2_axis_x_reg, s2_axis_y_reg;
    rsi_axis_t s2_axis_x_next, s2_axis_y_next;

    // Stage 3: determinant and numerators
    logic      s3_valid_reg;
    dsum_t     s3_den_reg, s3_tn_reg;
    csum_t     s3_un_reg;
    rsi_axis_t s3_axis_x_reg, s3_axis_y_reg;

    // Stage 4: sign normalized
    logic      s4_valid_reg;
    logic      s4_den_nz_reg;
    mag_t      s4_den_reg;
    dsum_t     s4_tn_reg;
    csum_t     s4_un_reg;
    rsi_axis_t s4_axis_x_reg, s4_axis_y_reg;

    // Stage 5: hit decided
    logic      s5_valid_reg;
    logic      s5_hit_reg;
    logic      s5_hit_next;
    mag_t      s5_den_reg;
    mag_t      s5_tn_reg;
    rsi_axis_t s5_axis_x_reg, s5_axis_y_reg;

    // Divider
    rsi_ctl_t  div_ctl_in;
    rsi_axis_t div_axis_in [AXES];
    rsi_ctl_t  div_ctl;
    mag_t      div_den;
    rsi_axis_t div_axis [AXES];
    rsi_lane_t div_lane [AXES];

    // Rounding stage
    logic      r1_valid_reg;
    logic      r1_hit_reg;
    logic      r1_rnd_x_reg, r1_rnd_y_reg;
    quo_t      r1_q_x_reg, r1_q_y_reg;
    rsi_axis_t r1_axis_x_reg, r1_axis_y_reg;
    rsi_res_t  fin_res;

    // Output register and skid entry
    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    rsi_res_t  out_reg, skid_reg;
    logic      load_out_fin, load_out_skid, load_skid;

    // Place the point on one axis: p1 +/- (q + rnd), saturated
    function automatic coord_t place(input rsi_axis_t a, input quo_t q, input logic rnd);
        pt_t qz;
        pt_t sum;
        coord_t res;
        qz  = pt_t'(q);
        sum = pt_t'(a.p1) + (a.neg ? ~qz : qz) + pt_t'(a.neg ? !rnd : rnd);
        priority if (sum > PT_MAX)
        begin
            res = PT_MAX[COORD_W-1:0];
        end
        else if (sum < PT_MIN)
        begin
            res = PT_MIN[COORD_W-1:0];
        end
        else
        begin
            res = sum[COORD_W-1:0];
        end
        return res;
    endfunction

    // Hold the whole pipeline while the skid entry is occupied
    assign adv       = !skid_valid_reg;
    assign ray.ready = adv;

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            r1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= ray.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            r1_valid_reg <= div_ctl.valid;
        end
    end

    // Stage 1: wall delta and offset of the first endpoint from the origin
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ex_reg <= diff_t'(ray.wall_start_x) - diff_t'(ray.wall_end_x);
            s1_ey_reg <= diff_t'(ray.wall_start_y) - diff_t'(ray.wall_end_y);
            s1_ax_reg <= diff_t'(ray.wall_start_x) - diff_t'(ray.origin_x);
            s1_ay_reg <= diff_t'(ray.wall_start_y) - diff_t'(ray.origin_y);
            s1_rx_reg <= ray.dir_x;
            s1_ry_reg <= ray.dir_y;
            s1_x1_reg <= ray.wall_start_x;
            s1_y1_reg <= ray.wall_start_y;
        end
    end

    // Split the wall delta (end minus start) into sign and magnitude per axis
    always_comb
    begin
        s2_axis_x_next.p1  = s1_x1_reg;
        s2_axis_x_next.neg = !s1_ex_reg[DIFF_W-1] && (s1_ex_reg != '0);
        s2_axis_x_next.mag = s1_ex_reg[DIFF_W-1] ? emag_t'(-s1_ex_reg) : emag_t'(s1_ex_reg);
        s2_axis_y_next.p1  = s1_y1_reg;
        s2_axis_y_next.neg = !s1_ey_reg[DIFF_W-1] && (s1_ey_reg != '0);
        s2_axis_y_next.mag = s1_ey_reg[DIFF_W-1] ? emag_t'(-s1_ey_reg) : emag_t'(s1_ey_reg);
    end

    // Stage 2: the six cross products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_eyrx_reg   <= dprod_t'(s1_ey_reg) * dprod_t'(s1_rx_reg);
            s2_exry_reg   <= dprod_t'(s1_ex_reg) * dprod_t'(s1_ry_reg);
            s2_ayrx_reg   <= dprod_t'(s1_ay_reg) * dprod_t'(s1_rx_reg);
            s2_axry_reg   <= dprod_t'(s1_ax_reg) * dprod_t'(s1_ry_reg);
            s2_eyax_reg   <= cprod_t'(s1_ey_reg) * cprod_t'(s1_ax_reg);
            s2_exay_reg   <= cprod_t'(s1_ex_reg) * cprod_t'(s1_ay_reg);
            s2_axis_x_reg <= s2_axis_x_next;
            s2_axis_y_reg <= s2_axis_y_next;
        end
    end

    // Stage 3: determinant, segment numerator, ray numerator
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_den_reg    <= dsum_t'(s2_eyrx_reg) - dsum_t'(s2_exry_reg);
            s3_tn_reg     <= dsum_t'(s2_ayrx_reg) - dsum_t'(s2_axry_reg);
            s3_un_reg     <= csum_t'(s2_eyax_reg) - csum_t'(s2_exay_reg);
            s3_axis_x_reg <= s2_axis_x_reg;
            s3_axis_y_reg <= s2_axis_y_reg;
        end
    end

    // Stage 4: flip all three so the determinant is not negative
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_den_nz_reg <= (s3_den_reg != '0);
            s4_den_reg    <= $unsigned(s3_den_reg[DSUM_W-1] ? -s3_den_reg : s3_den_reg);
            s4_tn_reg     <= s3_den_reg[DSUM_W-1] ? -s3_tn_reg : s3_tn_reg;
            s4_un_reg     <= s3_den_reg[DSUM_W-1] ? -s3_un_reg : s3_un_reg;
            s4_axis_x_reg <= s3_axis_x_reg;
            s4_axis_y_reg <= s3_axis_y_reg;
        end
    end

    // Hit needs 0 < tn < den and un > 0 on a nonzero determinant
    always_comb
    begin
        s5_hit_next = s4_den_nz_reg
                   && !s4_tn_reg[DSUM_W-1] && (s4_tn_reg != '0)
                   && ($unsigned(s4_tn_reg) < s4_den_reg)
                   && !s4_un_reg[CSUM_W-1] && (s4_un_reg != '0);
    end

    // Stage 5
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_hit_reg <= 1'b0;
        end
        else if (adv)
        begin
            s5_hit_reg <= s5_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_den_reg    <= s4_den_reg;
            s5_tn_reg     <= $unsigned(s4_tn_reg);
            s5_axis_x_reg <= s4_axis_x_reg;
            s5_axis_y_reg <= s4_axis_y_reg;
        end
    end

    // Divide both axes in parallel lanes
    assign div_ctl_in.valid = s5_valid_reg;
    assign div_ctl_in.hit   = s5_hit_reg;
    assign div_axis_in      = '{s5_axis_x_reg, s5_axis_y_reg};

    rsi_div_pipe u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_ctl   (div_ctl_in),
        .in_den   (s5_den_reg),
        .in_tn    (s5_tn_reg),
        .in_axis  (div_axis_in),
        .out_ctl  (div_ctl),
        .out_den  (div_den),
        .out_axis (div_axis),
        .out_lane (div_lane)
    );

    // Rounding stage: round half up when twice the remainder reaches the divisor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_hit_reg <= 1'b0;
        end
        else if (adv)
        begin
            r1_hit_reg <= div_ctl.hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r1_rnd_x_reg  <= {div_lane[AXIS_X].r, 1'b0} >= {1'b0, div_den};
            r1_rnd_y_reg  <= {div_lane[AXIS_Y].r, 1'b0} >= {1'b0, div_den};
            r1_q_x_reg    <= div_lane[AXIS_X].q;
            r1_q_y_reg    <= div_lane[AXIS_Y].q;
            r1_axis_x_reg <= div_axis[AXIS_X];
            r1_axis_y_reg <= div_axis[AXIS_Y];
        end
    end

    // Final point, zero on a miss
    always_comb
    begin
        fin_res.hit     = r1_hit_reg;
        fin_res.point_x = r1_hit_reg ? place(r1_axis_x_reg, r1_q_x_reg, r1_rnd_x_reg) : '0;
        fin_res.point_y = r1_hit_reg ? place(r1_axis_y_reg, r1_q_y_reg, r1_rnd_y_reg) : '0;
    end

    // Output register and skid entry: route each finished transaction
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out_fin    = 1'b0;
        load_out_skid   = 1'b0;
        load_skid       = 1'b0;
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (skid_valid_reg)
        begin
            if (result.ready)
            begin
                load_out_skid   = 1'b1;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (r1_valid_reg)
        begin
            if (!out_valid_reg || result.ready)
            begin
                load_out_fin   = 1'b1;
                out_valid_next = 1'b1;
            end
            else
            begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out_fin)
        begin
            out_reg <= fin_res;
        end
        else if (load_out_skid)
        begin
            out_reg <= skid_reg;
        end
        if (load_skid)
        begin
            skid_reg <= fin_res;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.hit     = out_reg.hit;
    assign result.point_x = out_reg.point_x;
    assign result.point_y = out_reg.point_y;

    // Skid entry only fills behind a waiting result; a miss carries a zero point
    `RSI_ASSERT_NOW(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `RSI_ASSERT_NOW(a_miss_is_zero, clk, rst_n, out_valid_reg && !out_reg.hit, out_reg.point_x == '0 && out_reg.point_y == '0)
    `RSI_ASSERT_NEXT(a_skid_stays_empty, clk, rst_n, result.ready && !skid_valid_reg, !skid_valid_reg)

endmodule

>>> hdl/rsi_div_pipe.sv
// Pipelined restoring divider: floor(tn * |delta| / den) and its remainder for both axes.
// One quotient bit per stage; depends on rsi_pkg and the assertion macros.
`include "ray_segment_intersection_unit_assert.svh"

module rsi_div_pipe
    import rsi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      adv,
    input  rsi_ctl_t  in_ctl,
    input  mag_t      in_den,
    input  mag_t      in_tn,
    input  rsi_axis_t in_axis  [AXES],
    output rsi_ctl_t  out_ctl,
    output mag_t      out_den,
    output rsi_axis_t out_axis [AXES],
    output rsi_lane_t out_lane [AXES]
);
    localparam int LAST = STEPS - 1;

    rsi_ctl_t  ctl_reg  [STEPS];
    mag_t      den_reg  [STEPS];
    mag_t      tn_reg   [STEPS-1];
    rsi_axis_t axis_reg [STEPS][AXES];
    rsi_lane_t lane_reg [STEPS][AXES];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        rsi_ctl_t ctl_src;
        mag_t     den_src;
        mag_t     tn_src;

        // Select the stage input: port for the first stage, previous stage otherwise
        if (k == 0) begin : g_head
            assign ctl_src = in_ctl;
            assign den_src = in_den;
            assign tn_src  = in_tn;
        end
        else begin : g_body
            assign ctl_src = ctl_reg[k-1];
            assign den_src = den_reg[k-1];
            assign tn_src  = tn_reg[k-1];
        end

        // Advance the valid and hit bits
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[k] <= '0;
            end
            else if (adv)
            begin
                ctl_reg[k] <= ctl_src;
            end
        end

        // Advance the divisor
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                den_reg[k] <= den_src;
            end
        end

        // Advance the numerator; the last stage no longer needs it
        if (k < LAST) begin : g_tn
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    tn_reg[k] <= tn_src;
                end
            end
        end

        for (genvar j = 0; j < AXES; j++) begin : g_lane
            rsi_axis_t        axis_src;
            rsi_lane_t        lane_src;
            rsi_lane_t        lane_next;
            logic [SUM_W-1:0] part;
            logic [SUM_W-1:0] den1;
            logic [SUM_W-1:0] den2;
            logic [SUM_W-1:0] rem;
            logic [1:0]       digit;

            if (k == 0) begin : g_head
                assign axis_src = in_axis[j];
                assign lane_src = '0;
            end
            else begin : g_body
                assign axis_src = axis_reg[k-1][j];
                assign lane_src = lane_reg[k-1][j];
            end

            // Shift in the next delta bit; on a hit the partial remainder stays below
            // 3*den, so at most two subtractions settle the digit
            always_comb
            begin
                den1 = {2'b00, den_src};
                den2 = {1'b0, den_src, 1'b0};
                part = {1'b0, lane_src.r, 1'b0}
                     + (axis_src.mag[EW-1-k] ? {2'b00, tn_src} : '0);
                priority if (part >= den2)
                begin
                    digit = 2'd2;
                    rem   = part - den2;
                end
                else if (part >= den1)
                begin
                    digit = 2'd1;
                    rem   = part - den1;
                end
                else
                begin
                    digit = 2'd0;
                    rem   = part;
                end
                lane_next.r = rem[MAG_W-1:0];
                lane_next.q = {lane_src.q[Q_W-2:0], 1'b0} + Q_W'(digit);
            end

            // Advance the lane
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    axis_reg[k][j] <= axis_src;
                    lane_reg[k][j] <= lane_next;
                end
            end
        end
    end

    // Drive the last stage out
    assign out_ctl = ctl_reg[LAST];
    assign out_den = den_reg[LAST];

    for (genvar j = 0; j < AXES; j++) begin : g_out
        assign out_axis[j] = axis_reg[LAST][j];
        assign out_lane[j] = lane_reg[LAST][j];
    end

    // A hit keeps every remainder below the divisor and every quotient below |delta|
    `RSI_ASSERT_NOW(a_rem_x_below_den, clk, rst_n, ctl_reg[LAST].valid && ctl_reg[LAST].hit, lane_reg[LAST][AXIS_X].r < den_reg[LAST])
    `RSI_ASSERT_NOW(a_rem_y_below_den, clk, rst_n, ctl_reg[LAST].valid && ctl_reg[LAST].hit, lane_reg[LAST][AXIS_Y].r < den_reg[LAST])
    `RSI_ASSERT_NOW(a_quo_below_delta, clk, rst_n, ctl_reg[LAST].valid && ctl_reg[LAST].hit, (lane_reg[LAST][AXIS_X].q < Q_W'(axis_reg[LAST][AXIS_X].mag) || lane_reg[LAST][AXIS_X].q == '0) && (lane_reg[LAST][AXIS_Y].q < Q_W'(axis_reg[LAST][AXIS_Y].mag) || lane_reg[LAST][AXIS_Y].q == '0))

endmodule
